// File: src/lzbd_pkg.sv
// shared types and constants of the lz block decompressor
package lzbd_pkg;

	localparam int unsigned OUT_ADDR_BITS = 16;
	localparam int unsigned TABLE_ENTRIES = 52;
	localparam int unsigned TAB_IDX_BITS  = 6;
	localparam int unsigned TAB_BASE_BITS = 21;

	localparam logic [7:0] CHECK_SUB  = 8'hAC;
	localparam logic [7:0] CHECK_INIT = 8'h80;
	localparam logic [7:0] CHECK_GOOD = 8'hFF;

	typedef enum logic [1:0] {
		OP_FEED    = 2'd0,
		OP_READ    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_FINISHED = 3'd1,
		ST_FORMAT   = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_CHECK = 4'd0,
		PH_ADDR  = 4'd1,
		PH_COUNT = 4'd2,
		PH_LASTF = 4'd3,
		PH_COMPF = 4'd4,
		PH_PFX   = 4'd5,
		PH_TAB   = 4'd6,
		PH_SYM   = 4'd7,
		PH_RUN   = 4'd8,
		PH_LEN   = 4'd9,
		PH_OSLOT = 4'd10,
		PH_OBITS = 4'd11,
		PH_LIT   = 4'd12,
		PH_DONE  = 4'd13,
		PH_ERR   = 4'd14
	} phase_t;

	typedef struct packed {
		logic take;
		logic step;
		logic lit_rd;
		logic lit_wr;
		logic cp_rd;
		logic cp_wr;
		logic resp;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic is_lit;
		logic over;
		logic done;
		logic copy_go;
		logic copy_more;
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// File: src/lzbd_in_if.sv
// input channel: operation and stream byte
interface lzbd_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [15:0] read_address;

	modport source (output valid, output operation, output data_byte, output last_byte,
		output read_address, input ready);
	modport sink (input valid, input operation, input data_byte, input last_byte,
		input read_address, output ready);
endinterface

// File: src/lzbd_out_if.sv
// result channel: status and readback data
interface lzbd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] read_data;
	logic       read_written;

	modport source (output valid, output status, output read_data, output read_written,
		input ready);
	modport sink (input valid, input status, input read_data, input read_written,
		output ready);
endinterface

// File: src/lzbd_datapath.sv
// decoder datapath: bit fields, prefix tables, output store and result register
module lzbd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  lzbd_pkg::cmd_t      cmd,
	output lzbd_pkg::sts_t      sts,
	input  logic [1:0]          operation,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [15:0]         read_address,
	lzbd_out_if.source          result
);
	import lzbd_pkg::*;

	logic [8:0] store [2**OUT_ADDR_BITS];
	logic [TAB_BASE_BITS+3:0] ptab [TABLE_ENTRIES];

	logic [7:0]  bitbuf_q, bitbuf_d;
	logic [3:0]  bits_q, bits_d;
	logic [16:0] wa_q, wa_d;
	logic [16:0] syms_q, syms_d;
	phase_t      phase_q, phase_d;
	logic [2:0]  far_q, far_d;
	logic [15:0] src_q, src_d;
	logic [16:0] run_q, run_d;
	logic [7:0]  chk_q, chk_d;
	logic        lastblk_q, lastblk_d;
	logic [4:0]  need_q, need_d;
	logic [4:0]  got_q, got_d;
	logic [15:0] val_q, val_d;
	logic [3:0]  slot_q, slot_d;
	logic [5:0]  cursor_q, cursor_d;
	logic [TAB_BASE_BITS-1:0] sum_q, sum_d;
	logic [5:0]  pick_q, pick_d;
	logic [15:0] mlen_q, mlen_d;
	logic        over_q, over_d;
	logic        wait_q, wait_d;
	op_t         op_q;
	logic        last_q, was_over_q;
	logic [7:0]  byte_q;
	logic [15:0] clr_q;

	logic [TAB_BASE_BITS+3:0] tab_rd_q;
	logic [8:0]  rda_q, rdb_q;
	logic        rea, reb;
	logic [15:0] ra, rb;
	logic        we;
	logic [15:0] wadr;
	logic [8:0]  wdat;
	logic        tab_we;
	logic [TAB_BASE_BITS+3:0] tab_wdat;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [7:0]  out_data_q;
	logic        out_written_q;

	logic        do_start;
	logic [TAB_BASE_BITS-1:0] tbase, tsum;
	logic [6:0]  tab_lim;
	logic [21:0] ml, offs;
	logic [7:0]  tsub;
	logic        cp_ok;

	assign tbase   = tab_rd_q[TAB_BASE_BITS+3:4];
	assign tab_lim = 7'd20 + (7'd1 << far_q);
	assign ml      = {1'b0, tbase} + {6'd0, val_q} + 22'd1;
	assign offs    = {1'b0, tbase} + {6'd0, val_q};
	assign tsub    = chk_q - CHECK_SUB;
	assign cp_ok   = rda_q[8] && !wa_q[16] && !rdb_q[8];

	always_comb begin
		bitbuf_d = bitbuf_q; bits_d = bits_q; wa_d = wa_q; syms_d = syms_q;
		phase_d = phase_q; far_d = far_q; src_d = src_q; run_d = run_q;
		chk_d = chk_q; lastblk_d = lastblk_q; need_d = need_q; got_d = got_q;
		val_d = val_q; slot_d = slot_q; cursor_d = cursor_q; sum_d = sum_q;
		pick_d = pick_q; mlen_d = mlen_q; over_d = over_q; wait_d = wait_q;
		do_start = 1'b0;
		tsum = sum_q;
		tab_we = 1'b0;
		tab_wdat = '0;
		sts = '0;
		we = 1'b0; wadr = wa_q[15:0]; wdat = {1'b1, byte_q};
		rea = 1'b0; ra = src_q; reb = 1'b0; rb = wa_q[15:0];

		if (cmd.take) begin
			if (operation == OP_READ) begin
				rea = 1'b1;
				ra  = read_address;
			end
			if (operation == OP_FEED && !over_q) begin
				chk_d = {tsub[0], tsub[7:1]} ^ data_byte;
				unique case (phase_q)
					PH_CHECK: begin
						phase_d = PH_ADDR; need_d = 5'd16; got_d = '0; val_d = '0;
					end
					PH_DONE: phase_d = PH_ERR;
					PH_ERR, PH_LIT: ;
					default: begin
						bitbuf_d = data_byte;
						bits_d   = 4'd8;
					end
				endcase
			end
		end

		if (cmd.lit_rd || cmd.cp_rd) reb = 1'b1;
		if (cmd.cp_rd) rea = 1'b1;

		if (cmd.lit_wr) begin
			if (wa_q[16] || rdb_q[8]) begin
				phase_d = PH_ERR;
			end else begin
				we = 1'b1;
				wa_d = wa_q + 17'd1;
				run_d = run_q - 17'd1;
				if (run_q == 17'd1) begin
					syms_d = syms_q - 17'd1;
					do_start = 1'b1;
				end
			end
		end

		if (cmd.cp_wr) begin
			if (!cp_ok) begin
				phase_d = PH_ERR;
			end else begin
				we = 1'b1;
				wdat = {1'b1, rda_q[7:0]};
				wa_d = wa_q + 17'd1;
				src_d = src_q + 16'd1;
				mlen_d = mlen_q - 16'd1;
				if (mlen_q == 16'd1) begin
					syms_d = syms_q - 17'd1;
					do_start = 1'b1;
				end
			end
			sts.copy_more = cp_ok && (mlen_q != 16'd1);
		end

		if (cmd.step) begin
			if (wait_q) begin
				need_d = {1'b0, tab_rd_q[3:0]};
				wait_d = 1'b0;
			end else if (phase_q == PH_CHECK || phase_q == PH_LIT || phase_q == PH_DONE
				|| phase_q == PH_ERR) begin
				sts.done = 1'b1;
			end else if (got_q >= need_q) begin
				got_d = '0;
				val_d = '0;
				unique case (phase_q)
					PH_ADDR: begin
						wa_d = {1'b0, val_q}; phase_d = PH_COUNT; need_d = 5'd16;
					end
					PH_COUNT: begin
						syms_d = {1'b0, val_q} + 17'd1; phase_d = PH_LASTF; need_d = 5'd1;
					end
					PH_LASTF: begin
						lastblk_d = val_q[0]; phase_d = PH_COMPF; need_d = 5'd1;
					end
					PH_COMPF: begin
						if (val_q == 16'd0) begin
							run_d = syms_q; syms_d = 17'd1; phase_d = PH_LIT;
						end else begin
							phase_d = PH_PFX; need_d = 5'd2;
						end
					end
					PH_PFX: begin
						far_d = {1'b0, val_q[1:0]} + 3'd2;
						cursor_d = '0; sum_d = '0;
						phase_d = PH_TAB; need_d = 5'd4;
					end
					PH_TAB: begin
						// each offset table restarts its base sum
						if (cursor_q == 6'd8 || cursor_q == 6'd12 || cursor_q == 6'd20)
							tsum = '0;
						tab_we = 1'b1;
						tab_wdat = {tsum, val_q[3:0]};
						sum_d = tsum + (TAB_BASE_BITS'(1) << val_q[3:0]);
						cursor_d = cursor_q + 6'd1;
						if ({1'b0, cursor_q} + 7'd1 < tab_lim) begin
							phase_d = PH_TAB; need_d = 5'd4;
						end else begin
							do_start = 1'b1;
						end
					end
					PH_SYM: begin
						if (val_q != 16'd0) begin
							slot_d = slot_q + 4'd1;
							if (slot_q + 4'd1 < 4'd9) begin
								phase_d = PH_SYM; need_d = 5'd1;
							end else begin
								phase_d = PH_RUN; need_d = 5'd8;
							end
						end else if (slot_q == 4'd0) begin
							run_d = 17'd1; phase_d = PH_LIT;
						end else begin
							pick_d = {2'd0, slot_q} - 6'd1;
							phase_d = PH_LEN; wait_d = 1'b1;
						end
					end
					PH_RUN: begin
						run_d = {1'b0, val_q} + 17'd17; phase_d = PH_LIT;
					end
					PH_LEN: begin
						mlen_d = ml[15:0];
						if (ml > 22'h00FFFF) begin
							phase_d = PH_ERR;
						end else if (ml == 22'd1) begin
							pick_d = 6'd8; phase_d = PH_OSLOT; need_d = 5'd2;
						end else if (ml == 22'd2) begin
							pick_d = 6'd12; phase_d = PH_OSLOT; need_d = 5'd3;
						end else begin
							pick_d = 6'd20; phase_d = PH_OSLOT; need_d = {2'd0, far_q};
						end
					end
					PH_OSLOT: begin
						pick_d = pick_q + val_q[5:0];
						phase_d = PH_OBITS; wait_d = 1'b1;
					end
					PH_OBITS: begin
						if (offs >= 22'h00FFFF) begin
							phase_d = PH_ERR;
						end else begin
							src_d = wa_q[15:0] - offs[15:0] - 16'd1;
							sts.copy_go = 1'b1;
						end
					end
					default: phase_d = PH_ERR;
				endcase
			end else if (bits_q == 4'd0) begin
				sts.done = 1'b1;
			end else begin
				val_d = {val_q[14:0], bitbuf_q[7]};
				bitbuf_d = {bitbuf_q[6:0], 1'b0};
				bits_d = bits_q - 4'd1;
				got_d = got_q + 5'd1;
			end
		end

		// start of the next symbol, or end of the block
		if (do_start) begin
			got_d = '0;
			val_d = '0;
			if (syms_d == 17'd0) begin
				if (lastblk_q) begin
					phase_d = (bitbuf_q != 8'd0) ? PH_ERR : PH_DONE;
				end else begin
					phase_d = PH_ADDR; need_d = 5'd16;
				end
			end else begin
				slot_d = '0; phase_d = PH_SYM; need_d = 5'd1;
			end
		end

		if (cmd.resp) begin
			if (op_q == OP_FEED && !was_over_q && last_q) over_d = 1'b1;
			if (op_q == OP_RESTART) begin
				bitbuf_d = '0; bits_d = '0; wa_d = '0; syms_d = '0; phase_d = PH_CHECK;
				far_d = 3'd2; src_d = '0; run_d = '0; chk_d = CHECK_INIT;
				lastblk_d = 1'b0; need_d = '0; got_d = '0; val_d = '0; slot_d = '0;
				cursor_d = '0; sum_d = '0; pick_d = '0; mlen_d = '0; over_d = 1'b0;
				wait_d = 1'b0;
			end
		end

		if (cmd.clr) begin
			we = 1'b1;
			wadr = clr_q;
			wdat = '0;
		end

		sts.is_lit   = (phase_q == PH_LIT);
		sts.over     = over_q;
		sts.clr_last = (clr_q == 16'hFFFF);
		sts.out_free = !out_valid_q || result.ready;
	end

	always_ff @(posedge clk) begin
		if (we) store[wadr] <= wdat;
		if (rea) rda_q <= store[ra];
		if (reb) rdb_q <= store[rb];
	end

	always_ff @(posedge clk) begin
		if (tab_we) ptab[cursor_q] <= tab_wdat;
		tab_rd_q <= ptab[pick_d];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= op_t'(operation);
			last_q <= last_byte;
			was_over_q <= over_q;
			byte_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitbuf_q <= '0; bits_q <= '0; wa_q <= '0; syms_q <= '0; phase_q <= PH_CHECK;
			far_q <= 3'd2; src_q <= '0; run_q <= '0; chk_q <= CHECK_INIT;
			lastblk_q <= 1'b0; need_q <= '0; got_q <= '0; val_q <= '0; slot_q <= '0;
			cursor_q <= '0; sum_q <= '0; pick_q <= '0; mlen_q <= '0; over_q <= 1'b0;
			wait_q <= 1'b0; clr_q <= '0;
		end else begin
			bitbuf_q <= bitbuf_d; bits_q <= bits_d; wa_q <= wa_d; syms_q <= syms_d;
			phase_q <= phase_d; far_q <= far_d; src_q <= src_d; run_q <= run_d;
			chk_q <= chk_d; lastblk_q <= lastblk_d; need_q <= need_d; got_q <= got_d;
			val_q <= val_d; slot_q <= slot_d; cursor_q <= cursor_d; sum_q <= sum_d;
			pick_q <= pick_d; mlen_q <= mlen_d; over_q <= over_d; wait_q <= wait_d;
			if (cmd.clr) clr_q <= clr_q + 16'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			out_data_q <= '0;
			out_written_q <= 1'b0;
			out_status_q <= ST_ACCEPTED;
			if (op_q == OP_READ) begin
				out_data_q <= rda_q[7:0];
				out_written_q <= rda_q[8];
			end else if (op_q == OP_FEED) begin
				if (was_over_q) out_status_q <= ST_FORMAT;
				else if (last_q) begin
					if (chk_q != CHECK_GOOD) out_status_q <= ST_CHECKSUM;
					else if (phase_q == PH_ERR) out_status_q <= ST_FORMAT;
					else if (phase_q != PH_DONE) out_status_q <= ST_TRUNC;
					else out_status_q <= ST_FINISHED;
				end else if (phase_q == PH_ERR) out_status_q <= ST_FORMAT;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.read_data    = out_data_q;
	assign result.read_written = out_written_q;

endmodule

// File: src/lzbd_ctrl.sv
// controller: sequences intake, bit steps, store accesses and results
module lzbd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  logic [1:0]     operation,
	output logic           ready,
	output lzbd_pkg::cmd_t cmd,
	input  lzbd_pkg::sts_t sts
);
	import lzbd_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_STEP  = 8'b0000_0010,
		S_LITRD = 8'b0000_0100,
		S_LITWR = 8'b0000_1000,
		S_CPRD  = 8'b0001_0000,
		S_CPWR  = 8'b0010_0000,
		S_RESP  = 8'b0100_0000,
		S_CLEAR = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   restart_q;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (valid) begin
					cmd.take = 1'b1;
					if (operation == OP_FEED && !sts.over)
						state_d = sts.is_lit ? S_LITRD : S_STEP;
					else
						state_d = S_RESP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.done) state_d = S_RESP;
				else if (sts.copy_go) state_d = S_CPRD;
			end
			S_LITRD: begin
				cmd.lit_rd = 1'b1;
				state_d = S_LITWR;
			end
			S_LITWR: begin
				cmd.lit_wr = 1'b1;
				state_d = S_STEP;
			end
			S_CPRD: begin
				cmd.cp_rd = 1'b1;
				state_d = S_CPWR;
			end
			S_CPWR: begin
				cmd.cp_wr = 1'b1;
				state_d = sts.copy_more ? S_CPRD : S_STEP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d = restart_q ? S_CLEAR : S_IDLE;
				end
			end
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			restart_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take) restart_q <= (operation == OP_RESTART);
		end
	end

	a_cpwr_after_cprd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CPWR |-> $past(state_q == S_CPRD))
		else $error("copy write without read");
	a_litwr_after_litrd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LITWR |-> $past(state_q == S_LITRD))
		else $error("literal write without read");
	a_resp_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp |-> sts.out_free)
		else $error("result loaded over a pending one");
	a_clear_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !cmd.take && !cmd.step)
		else $error("item taken during clearing pass");

endmodule

// File: src/lz_block_decompressor_top.sv
// top level of the lz block decompressor
// One item is in work at a time; the next is taken as soon as the block is idle, while the
// previous result may still wait in the result register. Readback, restart, an ignored
// operation and a byte fed after the final one go from intake straight to the result. Any
// other fed byte passes intake, bit steps (one per bit shifted into a field, per field finished
// and per prefix table lookup) and the result; a literal byte adds a written-map check and a
// store write, and every byte of a match copy takes one store read and one store write. Every
// item also waits while the result register stays full. After reset and after every restart a
// clearing pass wipes the written map, one address a cycle, before the next item is taken.
module lz_block_decompressor_top (
	input logic        clk,
	input logic        arst_n,
	lzbd_in_if.sink    feed,
	lzbd_out_if.source result
);
	import lzbd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic ready;

	assign feed.ready = ready;

	lzbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (feed.valid),
		.operation (feed.operation),
		.ready     (ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lzbd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (feed.operation),
		.data_byte    (feed.data_byte),
		.last_byte    (feed.last_byte),
		.read_address (feed.read_address),
		.result       (result)
	);

endmodule

// File: test/tb_lz_block_decompressor_top.sv
// testbench of the lz block decompressor: encoded streams, readback and stalls on both sides
`timescale 1ns / 100ps

module tb_lz_block_decompressor_top;
	import lzbd_pkg::*;

	typedef struct {
		op_t         op;
		logic [7:0]  data;
		logic        last;
		logic [15:0] addr;
		status_t     st;
		logic [7:0]  rd;
		logic        rw;
	} lz_item_t;

	typedef enum int {
		SK_GOOD, SK_CHECKSUM, SK_TRUNC, SK_EXTRA, SK_TAIL, SK_DOUBLE,
		SK_OVERFLOW, SK_UNWRITTEN, SK_LONG, SK_FAROFF
	} stream_kind_t;

	typedef struct {
		int kind; // 0 literal, 1 run, 2 match
		int k, v, s0, sbits, os, ob, n;
	} sym_plan_t;

	logic clk;
	logic arst_n;

	lzbd_in_if  feed_if ();
	lzbd_out_if res_if ();

	lz_block_decompressor_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if),
		.result (res_if)
	);

	lz_item_t feed_q[$];
	lz_item_t result_q[$];
	lz_item_t drv_item;
	int       errors = 0;
	int       n_feeds = 0, n_reads = 0, n_streams = 0, n_results = 0;
	int       n_status[5] = '{0, 0, 0, 0, 0};

	// ---------------- decoder state of the predictor ----------------
	logic [7:0]  dec_mem [65536];
	bit          dec_map [65536];
	int unsigned dec_w [TABLE_ENTRIES];
	int unsigned dec_base [TABLE_ENTRIES];
	int unsigned dec_buf, dec_left, dec_wa, dec_syms, dec_far, dec_src, dec_run;
	int unsigned dec_need, dec_got, dec_val, dec_slot, dec_cur, dec_sum, dec_pick, dec_len;
	logic [7:0]  dec_chk;
	bit          dec_lastb, dec_over;
	phase_t      dec_ph;
	int unsigned written_addrs[$];

	function automatic logic [7:0] chk_fwd(logic [7:0] c, logic [7:0] b);
		logic [7:0] t;
		t = c - CHECK_SUB;
		return {t[0], t[7:1]} ^ b;
	endfunction

	function automatic logic [7:0] chk_back(logic [7:0] c, logic [7:0] b);
		logic [7:0] t;
		t = c ^ b;
		return {t[6:0], t[7]} + CHECK_SUB;
	endfunction

	task dec_reset();
		for (int i = 0; i < 65536; i++) dec_map[i] = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			dec_w[i] = 0;
			dec_base[i] = 0;
		end
		written_addrs.delete();
		dec_buf = 0; dec_left = 0; dec_wa = 0; dec_syms = 0; dec_far = 2; dec_src = 0;
		dec_run = 0; dec_chk = CHECK_INIT; dec_lastb = 0; dec_over = 0; dec_ph = PH_CHECK;
		dec_need = 0; dec_got = 0; dec_val = 0; dec_slot = 0; dec_cur = 0; dec_sum = 0;
		dec_pick = 0; dec_len = 0;
	endtask

	task dec_field(phase_t p, int unsigned n);
		dec_ph = p;
		dec_need = n;
		dec_got = 0;
		dec_val = 0;
	endtask

	task dec_start_symbol();
		if (dec_syms == 0) begin
			if (dec_lastb) dec_ph = (dec_buf != 0) ? PH_ERR : PH_DONE;
			else dec_field(PH_ADDR, 16);
		end else begin
			dec_slot = 0;
			dec_field(PH_SYM, 1);
		end
	endtask

	task dec_end_symbol();
		dec_syms--;
		dec_start_symbol();
	endtask

	function bit dec_put(logic [7:0] v);
		if (dec_wa > 32'hFFFF || dec_map[dec_wa]) begin
			dec_ph = PH_ERR;
			return 0;
		end
		dec_mem[dec_wa] = v;
		dec_map[dec_wa] = 1;
		written_addrs = {written_addrs, dec_wa};
		dec_wa++;
		return 1;
	endfunction

	task dec_copy(int unsigned offs);
		dec_src = (dec_wa - offs) & 32'hFFFF;
		for (int unsigned j = 0; j < dec_len; j++) begin
			if (!dec_map[dec_src]) begin
				dec_ph = PH_ERR;
				return;
			end
			if (!dec_put(dec_mem[dec_src])) return;
			dec_src = (dec_src + 1) & 32'hFFFF;
		end
		dec_end_symbol();
	endtask

	task dec_finish_field();
		int unsigned v, offs;
		v = dec_val;
		case (dec_ph)
			PH_ADDR: begin
				dec_wa = v;
				dec_field(PH_COUNT, 16);
			end
			PH_COUNT: begin
				dec_syms = v + 1;
				dec_field(PH_LASTF, 1);
			end
			PH_LASTF: begin
				dec_lastb = v[0];
				dec_field(PH_COMPF, 1);
			end
			PH_COMPF: begin
				if (v == 0) begin
					dec_run = dec_syms;
					dec_syms = 1;
					dec_ph = PH_LIT;
				end else dec_field(PH_PFX, 2);
			end
			PH_PFX: begin
				dec_far = v + 2;
				dec_cur = 0;
				dec_sum = 0;
				dec_field(PH_TAB, 4);
			end
			PH_TAB: begin
				if (dec_cur == 8 || dec_cur == 12 || dec_cur == 20) dec_sum = 0;
				dec_w[dec_cur % TABLE_ENTRIES] = v;
				dec_base[dec_cur % TABLE_ENTRIES] = dec_sum;
				dec_sum += 1 << v;
				dec_cur++;
				if (dec_cur < 20 + (1 << dec_far)) dec_field(PH_TAB, 4);
				else dec_start_symbol();
			end
			PH_SYM: begin
				if (v != 0) begin
					dec_slot++;
					if (dec_slot < 9) dec_field(PH_SYM, 1);
					else dec_field(PH_RUN, 8);
				end else if (dec_slot == 0) begin
					dec_run = 1;
					dec_ph = PH_LIT;
				end else begin
					dec_pick = dec_slot - 1;
					dec_field(PH_LEN, dec_w[dec_pick % TABLE_ENTRIES]);
				end
			end
			PH_RUN: begin
				dec_run = v + 17;
				dec_ph = PH_LIT;
			end
			PH_LEN: begin
				dec_len = dec_base[dec_pick % TABLE_ENTRIES] + v + 1;
				if (dec_len > 32'hFFFF) dec_ph = PH_ERR;
				else if (dec_len == 1) begin
					dec_pick = 8;
					dec_field(PH_OSLOT, 2);
				end else if (dec_len == 2) begin
					dec_pick = 12;
					dec_field(PH_OSLOT, 3);
				end else begin
					dec_pick = 20;
					dec_field(PH_OSLOT, dec_far);
				end
			end
			PH_OSLOT: begin
				dec_pick += v;
				dec_field(PH_OBITS, dec_w[dec_pick % TABLE_ENTRIES]);
			end
			PH_OBITS: begin
				offs = dec_base[dec_pick % TABLE_ENTRIES] + v;
				if (offs >= 32'hFFFF) dec_ph = PH_ERR;
				else dec_copy(offs + 1);
			end
			default: dec_ph = PH_ERR;
		endcase
	endtask

	task dec_advance();
		while (dec_ph >= PH_ADDR && dec_ph <= PH_OBITS) begin
			if (dec_got >= dec_need) dec_finish_field();
			else if (dec_left == 0) break;
			else begin
				dec_val = (dec_val << 1) | ((dec_buf >> 7) & 1);
				dec_buf = (dec_buf << 1) & 8'hFF;
				dec_left--;
				dec_got++;
			end
		end
	endtask

	// works out the result of one item and advances the decoder state
	task decode_item(inout lz_item_t it);
		it.st = ST_ACCEPTED;
		it.rd = '0;
		it.rw = 1'b0;
		case (it.op)
			OP_READ: begin
				it.rd = dec_mem[it.addr];
				it.rw = dec_map[it.addr];
			end
			OP_RESTART: dec_reset();
			OP_FEED: begin
				if (dec_over) it.st = ST_FORMAT;
				else begin
					dec_chk = chk_fwd(dec_chk, it.data);
					case (dec_ph)
						PH_CHECK: dec_field(PH_ADDR, 16);
						PH_LIT: begin
							if (dec_put(it.data)) begin
								dec_run--;
								if (dec_run == 0) dec_end_symbol();
							end
						end
						PH_DONE: dec_ph = PH_ERR;
						PH_ERR: ;
						default: begin
							dec_buf = it.data;
							dec_left = 8;
						end
					endcase
					dec_advance();
					if (it.last) begin
						dec_over = 1;
						if (dec_chk != CHECK_GOOD) it.st = ST_CHECKSUM;
						else if (dec_ph == PH_ERR) it.st = ST_FORMAT;
						else if (dec_ph != PH_DONE) it.st = ST_TRUNC;
						else it.st = ST_FINISHED;
						n_status[it.st]++;
					end else if (dec_ph == PH_ERR) it.st = ST_FORMAT;
				end
			end
			default: ;
		endcase
	endtask

	task add_item(op_t op, logic [7:0] data, logic last, logic [15:0] addr);
		lz_item_t it;
		it.op = op;
		it.data = data;
		it.last = last;
		it.addr = addr;
		decode_item(it);
		if (op == OP_FEED) n_feeds++;
		if (op == OP_READ) n_reads++;
		feed_q = {feed_q, it};
	endtask

	task add_readback();
		if (written_addrs.size() > 0)
			add_item(OP_READ, 8'($urandom), 1'($urandom), 16'(written_addrs[$urandom_range(0,
				written_addrs.size() - 1)]));
	endtask

	// ---------------- stream encoder ----------------
	logic [7:0]  enc_bytes[$];
	int          enc_idx, enc_pos;
	bit          enc_map [65536];
	int unsigned enc_w [TABLE_ENTRIES];
	int unsigned enc_base [TABLE_ENTRIES];
	int unsigned enc_far, prev_region;

	task put_bits(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) begin
			if (enc_pos == 8) begin
				enc_bytes = {enc_bytes, 8'h00};
				enc_idx = enc_bytes.size() - 1;
				enc_pos = 0;
			end
			if (v[i]) enc_bytes[enc_idx][7 - enc_pos] = 1'b1;
			enc_pos++;
		end
	endtask

	// whole bytes go straight after the byte that is being unpacked
	task put_literal();
		enc_bytes = {enc_bytes, 8'($urandom)};
	endtask

	task put_header(int unsigned a, int unsigned cnt, bit last, bit comp);
		put_bits(a, 16);
		put_bits(cnt - 1, 16);
		put_bits(last, 1);
		put_bits(comp, 1);
	endtask

	task pick_region(int unsigned t, output int unsigned a);
		bit ok;
		for (int tries = 0; tries < 200; tries++) begin
			a = ($urandom_range(0, 3) == 0) ? 65536 - t : $urandom_range(0, 65536 - t);
			ok = 1;
			for (int unsigned j = 0; j < t; j++) if (enc_map[a + j]) ok = 0;
			if (ok) break;
		end
		for (int unsigned j = 0; j < t; j++) enc_map[a + j] = 1;
		prev_region = a;
	endtask

	task plain_block(int unsigned t, bit last);
		int unsigned a;
		pick_region(t, a);
		put_header(a, t, last, 0);
		repeat (t) put_literal();
	endtask

	task set_tables();
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < 20 + (1 << enc_far); i++) begin
			if (i == 8 || i == 12 || i == 20) sum = 0;
			enc_base[i] = sum;
			sum += 1 << enc_w[i];
		end
	endtask

	task comp_block(int unsigned t, bit last);
		int unsigned a, w, stop, len, offs, src;
		bit ok;
		sym_plan_t p;
		sym_plan_t plan[$];
		enc_far = $urandom_range(2, 5);
		for (int i = 0; i < 20 + (1 << enc_far); i++)
			enc_w[i] = (i < 8) ? $urandom_range(0, 2) : (i < 12) ? $urandom_range(0, 3) :
				(i < 20) ? $urandom_range(0, 4) : $urandom_range(0, 5);
		set_tables();
		pick_region(t, a);
		for (int unsigned j = 0; j < t; j++) enc_map[a + j] = 0;
		w = a;
		stop = a + t;
		while (w < stop) begin
			p = '{0, 0, 0, 0, 0, 0, 0, 1};
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					p.k = $urandom_range(1, 8);
					p.v = $urandom_range(0, (1 << enc_w[p.k - 1]) - 1);
					len = enc_base[p.k - 1] + p.v + 1;
					if (len == 1) begin p.s0 = 8; p.sbits = 2; end
					else if (len == 2) begin p.s0 = 12; p.sbits = 3; end
					else begin p.s0 = 20; p.sbits = enc_far; end
					p.os = $urandom_range(0, (1 << p.sbits) - 1);
					p.ob = $urandom_range(0, (1 << enc_w[p.s0 + p.os]) - 1);
					offs = enc_base[p.s0 + p.os] + p.ob + 1;
					ok = (len <= stop - w);
					// overlapping copies read back what they have just written
					for (int unsigned j = 0; j < len && ok; j++) begin
						src = (w - offs + j) & 32'hFFFF;
						if (j < offs && !enc_map[src]) ok = 0;
					end
					if (ok) begin
						p.kind = 2;
						p.n = len;
					end
				end
				5: if (stop - w >= 17) begin
					p.kind = 1;
					p.n = $urandom_range(17, (stop - w > 272) ? 272 : stop - w);
				end
				default: ;
			endcase
			for (int unsigned j = 0; j < p.n; j++) enc_map[w + j] = 1;
			w += p.n;
			plan = {plan, p};
		end
		put_header(a, plan.size(), last, 1);
		put_bits(enc_far - 2, 2);
		for (int i = 0; i < 20 + (1 << enc_far); i++) put_bits(enc_w[i], 4);
		foreach (plan[i]) begin
			case (plan[i].kind)
				0: begin
					put_bits(0, 1);
					put_literal();
				end
				1: begin
					put_bits(9'h1FF, 9);
					put_bits(plan[i].n - 17, 8);
					repeat (plan[i].n) put_literal();
				end
				default: begin
					put_bits(((1 << plan[i].k) - 1) << 1, plan[i].k + 1);
					put_bits(plan[i].v, enc_w[plan[i].k - 1]);
					put_bits(plan[i].os, plan[i].sbits);
					put_bits(plan[i].ob, enc_w[plan[i].s0 + plan[i].os]);
				end
			endcase
		end
	endtask

	// match to reject (huge length/far tables): unwritten source, too long, too far
	task bad_match_block(stream_kind_t kind);
		int unsigned a;
		enc_far = 2;
		for (int i = 0; i < 24; i++) enc_w[i] = (i < 8 || i >= 20) ? 15 : 0;
		set_tables();
		pick_region(1, a);
		put_header(a, 1, 1, 1);
		put_bits(0, 2);
		for (int i = 0; i < 24; i++) put_bits(enc_w[i], 4);
		case (kind)
			SK_UNWRITTEN: begin
				put_bits(2'b10, 2);
				put_bits(0, 15);
				put_bits(0, 2);
			end
			SK_LONG: begin
				put_bits(9'h1FE, 9);
				put_bits(15'h7FFF, 15);
			end
			default: begin
				put_bits(2'b10, 2);
				put_bits(2, 15);
				put_bits(3, 2);
				put_bits(0, 15);
			end
		endcase
	endtask

	task build_and_send(stream_kind_t kind, int n_blocks, int max_t, int n_reads);
		logic [7:0] c;
		int         cut;
		enc_bytes.delete();
		enc_bytes = {enc_bytes, 8'h00};
		enc_idx = 0;
		enc_pos = 8;
		if (kind == SK_GOOD) begin
			for (int i = 0; i < n_blocks; i++)
				if ($urandom_range(0, 2) == 0) plain_block($urandom_range(1, max_t),
					i == n_blocks - 1);
				else comp_block($urandom_range(1, max_t), i == n_blocks - 1);
		end else begin
			if (kind != SK_UNWRITTEN) plain_block($urandom_range(1, 6), 0);
			case (kind)
				SK_DOUBLE: begin
					put_header(prev_region, 1, 1, 0);
					put_literal();
				end
				SK_OVERFLOW: begin
					put_header(16'hFFFF, 2, 1, 0);
					repeat (2) put_literal();
				end
				SK_UNWRITTEN, SK_LONG, SK_FAROFF: bad_match_block(kind);
				default: comp_block($urandom_range(4, 20), 1);
			endcase
		end
		case (kind)
			SK_TRUNC: begin
				cut = $urandom_range(1, (enc_bytes.size() > 4) ? 3 : 1);
				repeat (cut) void'(enc_bytes.pop_back());
			end
			SK_EXTRA: enc_bytes = {enc_bytes, 8'($urandom)};
			SK_TAIL: begin
				if (enc_pos < 8) enc_bytes[enc_idx][7 - enc_pos] = 1'b1;
				else enc_bytes = {enc_bytes, 8'($urandom_range(1, 255))};
			end
			default: ;
		endcase
		// the check byte is solved backwards from the good end value
		c = CHECK_GOOD;
		for (int i = enc_bytes.size() - 1; i >= 1; i--) c = chk_back(c, enc_bytes[i]);
		enc_bytes[0] = c ^ chk_fwd(CHECK_INIT, 8'h00);
		if (kind == SK_CHECKSUM) enc_bytes[0] ^= 8'h01 << $urandom_range(0, 7);

		foreach (enc_bytes[i]) begin
			if ($urandom_range(0, 29) == 0)
				add_item(OP_NONE, 8'($urandom), 1'($urandom), 16'($urandom));
			if ($urandom_range(0, 24) == 0) add_readback();
			add_item(OP_FEED, enc_bytes[i], i == enc_bytes.size() - 1, 16'($urandom));
		end
		// a byte after the final one gets a format error
		add_item(OP_FEED, 8'($urandom), 1'($urandom), 16'($urandom));
		repeat (n_reads) add_readback();
		add_item(OP_RESTART, 8'($urandom), 1'($urandom), 16'($urandom));
		for (int i = 0; i < 65536; i++) enc_map[i] = 0;
		n_streams++;
	endtask

	// ---------------- clock, driver and monitor ----------------
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	bit in_took = 0, res_took = 0;
	bit in_idle = 1, res_idle = 1;
	int in_gap = 0, res_stall = 0;

	function int draw_wait(inout bit idle_on);
		if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
		return idle_on ? $urandom_range(0, 15) : 0;
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			feed_if.valid <= 1'b0;
			feed_if.operation <= OP_NONE;
			feed_if.data_byte <= '0;
			feed_if.last_byte <= 1'b0;
			feed_if.read_address <= '0;
		end else if (!(feed_if.valid && !in_took)) begin
			if (in_took) in_gap = draw_wait(in_idle);
			if (in_gap > 0) begin
				in_gap--;
				feed_if.valid <= 1'b0;
			end else if (feed_q.size() > 0) begin
				drv_item = feed_q.pop_front();
				feed_if.operation <= drv_item.op;
				feed_if.data_byte <= drv_item.data;
				feed_if.last_byte <= drv_item.last;
				feed_if.read_address <= drv_item.addr;
				feed_if.valid <= 1'b1;
			end else begin
				feed_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_took) begin
				// one long hold-off so that the block fills up and refuses input
				if (n_results == 500) res_stall = 400;
				else res_stall = draw_wait(res_idle);
			end
			if (res_stall > 0) begin
				res_stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		lz_item_t want;
		if (arst_n) begin
			in_took <= feed_if.valid && feed_if.ready;
			res_took <= res_if.valid && res_if.ready;
			if (feed_if.valid && feed_if.ready) result_q = {result_q, drv_item};
			if (res_if.valid && res_if.ready) begin
				n_results++;
				if (result_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = result_q.pop_front();
					if (res_if.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, res_if.status);
						errors++;
					end
					if (res_if.read_data !== want.rd) begin
						$error("read_data: expected %02h, got %02h", want.rd, res_if.read_data);
						errors++;
					end
					if (res_if.read_written !== want.rw) begin
						$error("read_written: expected %0d, got %0d", want.rw,
							res_if.read_written);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		dec_reset();
		for (int i = 0; i < 65536; i++) enc_map[i] = 0;

		// directed: two literals at the very top of the store, extremes of every field
		enc_bytes.delete();
		enc_bytes = {enc_bytes, 8'h00};
		enc_idx = 0;
		enc_pos = 8;
		put_header(16'hFFFE, 2, 1, 0);
		enc_bytes = {enc_bytes, 8'h00};
		enc_bytes = {enc_bytes, 8'hFF};
		begin
			logic [7:0] c;
			c = CHECK_GOOD;
			for (int i = enc_bytes.size() - 1; i >= 1; i--) c = chk_back(c, enc_bytes[i]);
			enc_bytes[0] = c ^ chk_fwd(CHECK_INIT, 8'h00);
		end
		add_item(OP_NONE, 8'hFF, 1'b1, 16'hFFFF);
		foreach (enc_bytes[i]) add_item(OP_FEED, enc_bytes[i], i == enc_bytes.size() - 1,
			16'h0000);
		add_item(OP_FEED, 8'h00, 1'b1, 16'hFFFF);
		add_item(OP_READ, 8'h00, 1'b0, 16'hFFFE);
		add_item(OP_READ, 8'hFF, 1'b1, 16'hFFFF);
		add_item(OP_RESTART, 8'h00, 1'b0, 16'h0000);
		for (int i = 0; i < 65536; i++) enc_map[i] = 0;

		// random: long well-formed streams, then one stream for each way of breaking one
		for (int s = 0; s < 7; s++) build_and_send(SK_GOOD, $urandom_range(2, 4), 60, 25);
		for (int k = SK_CHECKSUM; k <= SK_FAROFF; k++)
			build_and_send(stream_kind_t'(k), 1, 20, 8);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (feed_q.size() > 0 || feed_if.valid) @(negedge clk);
		while (result_q.size() > 0) @(negedge clk);
		repeat (100) @(negedge clk);

		$display("%0d streams, %0d stream bytes, %0d readbacks, %0d results checked",
			n_streams, n_feeds, n_reads, n_results);
		$display("stream endings: %0d finished, %0d format error, %0d truncated, %0d bad check",
			n_status[ST_FINISHED], n_status[ST_FORMAT], n_status[ST_TRUNC],
			n_status[ST_CHECKSUM]);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
src/lzbd_pkg.sv
src/lzbd_in_if.sv
src/lzbd_out_if.sv
src/lzbd_datapath.sv
src/lzbd_ctrl.sv
src/lz_block_decompressor_top.sv
test/tb_lz_block_decompressor_top.sv
